// ===== rtl/seqras_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqras_pkg
// Shared sizes, codes and word types for the sequence range add/sum store.
// ----------------------------------------------------------------------------
package seqras_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 64;
  localparam int MODE_W   = 2;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = 11;
  localparam int LAST_W   = 12;
  // signed compare width that holds count, first and last without loss
  localparam int CMP_W    = ((CNT_W > LAST_W) ? CNT_W : LAST_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_ERASE  = 2'd1,
    MODE_ADD    = 2'd2,
    MODE_SUM    = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                    mode;
    logic [IDX_W-1:0]         first;
    logic signed [LAST_W-1:0] last;
    logic [DATA_W-1:0]        operand;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] range_sum;
    status_t           status;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

// ===== rtl/sequence_range_add_sum_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_range_add_sum_store
// Ordered store of signed 64-bit values with insert, erase, range add and
// range sum, one operation at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one operation word (mode, first_index,
//   last_index, operand_value); it is taken when in_valid is high and
//   in_stall is low. Each operation gives exactly one result word on the
//   output channel (range_sum, status, element_count).
//   Timing: an operation walks the value memory through its single read
//   port, one entry a cycle, with the write-back in the following cycle.
//   The entries touched are count - position for insert, count -
//   position - 1 for erase, and the clipped range length for add and
//   sum (0 for rejected or empty operations).
//   in_stall is high while an operation is in progress. A finished result
//   sits in the output register; the next operation is accepted while it
//   waits. When the receiver stalls, the result word holds and a following
//   operation stops in its final cycle until the register frees up.
//   Reset clears the entry count and both channels; memory contents are
//   not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sequence_range_add_sum_store (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [seqras_pkg::MODE_W-1:0]            in_mode,
  input  logic [seqras_pkg::IDX_W-1:0]             in_first_index,
  input  logic signed [seqras_pkg::LAST_W-1:0]     in_last_index,
  input  logic signed [seqras_pkg::DATA_W-1:0]     in_operand_value,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [seqras_pkg::DATA_W-1:0]     out_range_sum,
  output logic [seqras_pkg::STAT_W-1:0]            out_status,
  output logic [seqras_pkg::IDX_W-1:0]             out_element_count
);

  localparam int DATA_W = seqras_pkg::DATA_W;
  localparam int STAT_W = seqras_pkg::STAT_W;
  localparam int IDX_W  = seqras_pkg::IDX_W;

  seqras_pkg::cmd_t cmd;
  seqras_pkg::res_t res;
  logic             busy;
  logic             start;
  logic             res_take;
  logic             res_valid;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_sum_r;
  logic [STAT_W-1:0] out_status_r;
  logic [IDX_W-1:0]  out_count_r;

  assign cmd.mode    = seqras_pkg::mode_t'(in_mode);
  assign cmd.first   = in_first_index;
  assign cmd.last    = in_last_index;
  assign cmd.operand = in_operand_value;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign res_take = !out_valid_r || !out_stall;

  seqras_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_sum_r    <= res.range_sum;
      out_status_r <= res.status;
      out_count_r  <= IDX_W'(res.count);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_range_sum     = out_sum_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;

endmodule

// ===== rtl/seqras_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqras_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module seqras_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/seqras_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqras_engine
// Sequencer that walks the value memory for one operation: streams reads,
// writes each word back shifted or updated in the next cycle, or sums it.
// ----------------------------------------------------------------------------
module seqras_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  seqras_pkg::cmd_t   cmd,
  output logic               busy,
  input  logic               res_take,
  output logic               res_valid,
  output seqras_pkg::res_t   res
);

  localparam int ADDR_W = seqras_pkg::ADDR_W;
  localparam int CNT_W  = seqras_pkg::CNT_W;
  localparam int DATA_W = seqras_pkg::DATA_W;
  localparam int CMP_W  = seqras_pkg::CMP_W;
  localparam int IDX_W  = seqras_pkg::IDX_W;
  localparam int LAST_W = seqras_pkg::LAST_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  seqras_pkg::mode_t   mode_r, mode_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    rd_r, rd_nxt;
  logic [CNT_W-1:0]    wa_r, wa_nxt;
  logic                rv_r, rv_nxt;
  logic [DATA_W-1:0]   acc_r, acc_nxt;
  seqras_pkg::status_t status_r, status_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [DATA_W-1:0]   wdata;
  logic                re;
  logic [DATA_W-1:0]   rdata;

  logic signed [CMP_W-1:0] f_s, l_s, c_s, hi_s;
  logic                    empty;
  logic [CNT_W-1:0]        f_c, hi_c, ins_pos;

  seqras_ram #(
    .WIDTH (DATA_W),
    .DEPTH (seqras_pkg::CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // range clipping against the current count
  always_comb begin
    f_s     = $signed({{(CMP_W-IDX_W){1'b0}}, cmd.first});
    l_s     = {{(CMP_W-LAST_W){cmd.last[LAST_W-1]}}, cmd.last};
    c_s     = $signed({{(CMP_W-CNT_W){1'b0}}, count_r});
    empty   = (l_s < f_s) || (f_s >= c_s);
    hi_s    = (l_s >= c_s) ? CMP_W'(c_s - 1) : l_s;
    f_c     = f_s[CNT_W-1:0];
    hi_c    = hi_s[CNT_W-1:0];
    ins_pos = (f_s < c_s) ? f_c : count_r;
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    rd_nxt     = rd_r;
    wa_nxt     = wa_r;
    rv_nxt     = 1'b0;
    acc_nxt    = acc_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    we         = 1'b0;
    waddr      = wa_r[ADDR_W-1:0];
    wdata      = rdata;
    re         = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt  = S_RUN;
          mode_nxt   = cmd.mode;
          val_nxt    = cmd.operand;
          acc_nxt    = '0;
          status_nxt = seqras_pkg::ST_DONE;
          pos_nxt    = ins_pos;
          rem_nxt    = '0;
          rd_nxt     = f_c;
          unique case (cmd.mode)
            seqras_pkg::MODE_INSERT: begin
              if (count_r == CNT_W'(seqras_pkg::CAPACITY)) begin
                status_nxt = seqras_pkg::ST_FULL;
              end else begin
                // walk down from the top entry to the insert position
                rem_nxt = count_r - ins_pos;
                rd_nxt  = count_r - CNT_W'(1);
              end
            end
            seqras_pkg::MODE_ERASE: begin
              if (f_s >= c_s) begin
                status_nxt = seqras_pkg::ST_RANGE;
              end else begin
                rem_nxt = count_r - f_c - CNT_W'(1);
                rd_nxt  = f_c + CNT_W'(1);
              end
            end
            seqras_pkg::MODE_ADD,
            seqras_pkg::MODE_SUM: begin
              if (!empty) begin
                rem_nxt = hi_c - f_c + CNT_W'(1);
              end
            end
          endcase
        end
      end

      S_RUN: begin
        if (rem_r != '0) begin
          re      = 1'b1;
          rv_nxt  = 1'b1;
          rem_nxt = rem_r - CNT_W'(1);
          unique case (mode_r)
            seqras_pkg::MODE_INSERT: begin
              rd_nxt = rd_r - CNT_W'(1);
              wa_nxt = rd_r + CNT_W'(1);
            end
            seqras_pkg::MODE_ERASE: begin
              rd_nxt = rd_r + CNT_W'(1);
              wa_nxt = rd_r - CNT_W'(1);
            end
            seqras_pkg::MODE_ADD,
            seqras_pkg::MODE_SUM: begin
              rd_nxt = rd_r + CNT_W'(1);
              wa_nxt = rd_r;
            end
          endcase
        end

        // write back (or, for sum, accumulate) the word read in the previous cycle
        if (rv_r) begin
          if (mode_r == seqras_pkg::MODE_SUM) begin
            acc_nxt = acc_r + rdata;
          end else begin
            we = 1'b1;
            if (mode_r == seqras_pkg::MODE_ADD) begin
              wdata = rdata + val_r;
            end
          end
        end

        if (rem_r == '0 && !rv_r) begin
          state_nxt = S_FIN;
          if (status_r == seqras_pkg::ST_DONE) begin
            if (mode_r == seqras_pkg::MODE_INSERT) begin
              we        = 1'b1;
              waddr     = pos_r[ADDR_W-1:0];
              wdata     = val_r;
              count_nxt = count_r + CNT_W'(1);
            end else if (mode_r == seqras_pkg::MODE_ERASE) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
        end
      end

      S_FIN: begin
        // hold the result until the output register can take it
        if (res_take) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rv_r    <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
      count_r <= count_nxt;
    end
    mode_r   <= mode_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    rem_r    <= rem_nxt;
    rd_r     <= rd_nxt;
    wa_r     <= wa_nxt;
    acc_r    <= acc_nxt;
    status_r <= status_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign res.range_sum = acc_r;
  assign res.status    = status_r;
  assign res.count     = count_r;

endmodule
